// ===== hdl/bfbg_pkg.sv =====
`timescale 1ns / 1ps

package bfbg_pkg;

    typedef struct packed {
        logic       func;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_in_word;

    typedef struct packed {
        logic       valid_res;
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       was_cleared;
        logic       last_pixel;
    } t_out_word;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    typedef struct packed {
        logic [7:0] bright;
        logic [7:0] tol;
    } t_thresholds;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BRIGHT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd3;

    localparam logic [7:0] ALPHA_LIMIT  = 8'd2;
    localparam logic [7:0] BRIGHT_RESET = 8'd184;
    localparam logic [7:0] TOL_RESET    = 8'd40;
    localparam logic [7:0] DIM_RESET    = 8'd128;

endpackage

// ===== hdl/bfbg_classify.sv =====
`timescale 1ns / 1ps

module bfbg_classify (
    input  bfbg_pkg::t_pixel      i_pixel,
    input  bfbg_pkg::t_thresholds i_thr,
    output logic                  o_is_bg
);

    logic [7:0] hi_rg;
    logic [7:0] lo_rg;
    logic [7:0] hi;
    logic [7:0] lo;
    logic [7:0] spread;

    always_comb begin
        hi_rg   = (i_pixel.red > i_pixel.green) ? i_pixel.red : i_pixel.green;
        lo_rg   = (i_pixel.red < i_pixel.green) ? i_pixel.red : i_pixel.green;
        hi      = (hi_rg > i_pixel.blue) ? hi_rg : i_pixel.blue;
        lo      = (lo_rg < i_pixel.blue) ? lo_rg : i_pixel.blue;
        spread  = hi - lo;
        o_is_bg = (i_pixel.alpha <= bfbg_pkg::ALPHA_LIMIT)
                  || ((hi >= i_thr.bright) && (spread <= i_thr.tol));
    end

endmodule

// ===== hdl/border_flood_fill_bg_remove.sv =====
`timescale 1ns / 1ps

// Background remover for one RGBA8 image held on chip. Load words (func 0) store
// pixels in raster order and are taken back to back while the input is not stalled;
// the load that completes the image starts a fill, during which the input is stalled.
// The fill first clears the visited and cleared flags of every entry the previous
// fill used (the whole store for the first fill after reset), then reads and checks
// each border pixel, then for every background pixel it reaches does a queue read, a
// write that blanks the pixel, and a read and check of each neighbour, all through
// synchronous memories with one write and one read port each. Read words (func 1)
// each pass through a read-wait state before the next input word is taken, and return
// their result through the registered memory read and the output register; a
// two-deep output stage lets input words be taken while one result waits.
module border_flood_fill_bg_remove #(
    parameter int MAX_WIDTH  = 128,
    parameter int MAX_HEIGHT = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  bfbg_pkg::t_in_word                 i_in_word,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output bfbg_pkg::t_out_word                o_out_word,
    input  logic                               i_cfg_we,
    input  logic [bfbg_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [7:0]                         i_cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int LW    = (WW > HW) ? WW : HW;
    localparam int PRW   = WW + HW;
    localparam int PW    = YW + WW + 1;
    localparam int QW    = XW + YW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDW   = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_VIS   = 3'd3;
    localparam logic [2:0] S_CHK   = 3'd4;
    localparam logic [2:0] S_DEQ   = 3'd5;
    localparam logic [2:0] S_DEQ2  = 3'd6;

    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_RIGHT = 2'd1;
    localparam logic [1:0] NB_UP    = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    // Flag word layout: bit 1 cleared, bit 0 visited.
    localparam logic [1:0] FLAG_NONE    = 2'b00;
    localparam logic [1:0] FLAG_VISITED = 2'b01;
    localparam logic [1:0] FLAG_CLEARED = 2'b11;

    bfbg_pkg::t_pixel      r_pix_mem [DEPTH];
    logic [1:0]            r_flag_mem [DEPTH];
    logic [QW-1:0]         r_q_mem [DEPTH];
    bfbg_pkg::t_pixel      r_pix_rd;
    logic [1:0]            r_flag_rd;
    logic [QW-1:0]         r_q_rd;

    logic                  pix_we;
    logic [AW-1:0]         pix_waddr;
    bfbg_pkg::t_pixel      pix_wdata;
    logic [AW-1:0]         pm_raddr;
    logic                  flag_we;
    logic [AW-1:0]         flag_waddr;
    logic [1:0]            flag_wdata;
    logic                  q_we;
    logic [QW-1:0]         q_wdata;

    logic [2:0]            r_state, n_state;
    logic [7:0]            r_bright, n_bright;
    logic [7:0]            r_tol, n_tol;
    logic [7:0]            r_width_cfg, n_width_cfg;
    logic [7:0]            r_height_cfg, n_height_cfg;
    logic [AW-1:0]         r_load, n_load;
    logic [AW-1:0]         r_read, n_read;
    logic                  r_ready, n_ready;
    logic [TW-1:0]         r_dirty, n_dirty;
    logic [WW-1:0]         r_fw, n_fw;
    logic [HW-1:0]         r_fh, n_fh;
    logic [TW-1:0]         r_ftot, n_ftot;
    logic [TW-1:0]         r_cnt, n_cnt;
    logic                  r_seed, n_seed;
    logic                  r_sphase, n_sphase;
    logic                  r_sside, n_sside;
    logic [LW-1:0]         r_si, n_si;
    logic [XW-1:0]         r_px, n_px;
    logic [YW-1:0]         r_py, n_py;
    logic [1:0]            r_nb, n_nb;
    logic [XW-1:0]         r_cx, n_cx;
    logic [YW-1:0]         r_cy, n_cy;
    logic [AW-1:0]         r_vidx, n_vidx;
    logic [TW-1:0]         r_head, n_head;
    logic [TW-1:0]         r_tail, n_tail;
    logic                  r_rd_ok, n_rd_ok;
    logic                  r_rd_last, n_rd_last;
    logic                  r_out_v, n_out_v;
    bfbg_pkg::t_out_word   r_out, n_out;
    logic                  r_skid_v, n_skid_v;
    bfbg_pkg::t_out_word   r_skid, n_skid;

    logic [31:0]           w_eff32;
    logic [31:0]           h_eff32;
    logic [WW-1:0]         w_eff;
    logic [HW-1:0]         h_eff;
    logic [PRW-1:0]        tot_full;
    logic [PRW-1:0]        load_next;
    logic [PRW-1:0]        read_next;
    logic                  in_acc;
    logic                  out_take;
    logic [HW-1:0]         hm1;
    logic [WW-1:0]         wm1;
    logic [XW-1:0]         cand_x;
    logic [YW-1:0]         cand_y;
    logic                  cand_ok;
    logic [XW-1:0]         mul_x;
    logic [YW-1:0]         mul_y;
    logic [PW-1:0]         idx_full;
    logic [AW-1:0]         mul_idx;
    logic                  adv;
    logic                  seed_second;
    logic [LW-1:0]         seed_lim;
    logic                  is_bg;
    bfbg_pkg::t_thresholds thr;
    bfbg_pkg::t_out_word   rd_word;

    assign thr.bright = r_bright;
    assign thr.tol    = r_tol;

    bfbg_classify u_classify (
        .i_pixel (r_pix_rd),
        .i_thr   (thr),
        .o_is_bg (is_bg)
    );

    always_comb begin
        w_eff32 = (r_width_cfg == 8'd0) ? 32'd1
                : ((32'(r_width_cfg) > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : 32'(r_width_cfg));
        h_eff32 = (r_height_cfg == 8'd0) ? 32'd1
                : ((32'(r_height_cfg) > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT)
                                                         : 32'(r_height_cfg));
        w_eff     = w_eff32[WW-1:0];
        h_eff     = h_eff32[HW-1:0];
        tot_full  = PRW'(w_eff) * PRW'(h_eff);
        load_next = PRW'(r_load) + PRW'(1);
        read_next = PRW'(r_read) + PRW'(1);
    end

    assign o_in_stall  = (r_state != S_IDLE) || r_skid_v;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_take    = r_out_v && !i_out_stall;
    assign o_out_valid = r_out_v;
    assign o_out_word  = r_out;

    always_comb begin
        hm1     = r_fh - HW'(1);
        wm1     = r_fw - WW'(1);
        cand_x  = r_px;
        cand_y  = r_py;
        cand_ok = 1'b1;
        if (r_seed) begin
            if (!r_sphase) begin
                cand_x = r_si[XW-1:0];
                cand_y = r_sside ? hm1[YW-1:0] : '0;
            end else begin
                cand_x = r_sside ? wm1[XW-1:0] : '0;
                cand_y = r_si[YW-1:0];
            end
        end else begin
            case (r_nb)
                NB_LEFT: begin
                    cand_x  = r_px - XW'(1);
                    cand_ok = (r_px != '0);
                end
                NB_RIGHT: begin
                    cand_x  = r_px + XW'(1);
                    cand_ok = ((WW'(r_px) + WW'(1)) < r_fw);
                end
                NB_UP: begin
                    cand_y  = r_py - YW'(1);
                    cand_ok = (r_py != '0);
                end
                NB_DOWN: begin
                    cand_y  = r_py + YW'(1);
                    cand_ok = ((HW'(r_py) + HW'(1)) < r_fh);
                end
                default: begin
                    cand_ok = 1'b0;
                end
            endcase
        end
        mul_x    = (r_state == S_DEQ2) ? r_q_rd[QW-1:YW] : cand_x;
        mul_y    = (r_state == S_DEQ2) ? r_q_rd[YW-1:0] : cand_y;
        idx_full = PW'(mul_y) * PW'(r_fw) + PW'(mul_x);
        mul_idx  = idx_full[AW-1:0];
        seed_second = r_sphase ? (r_fw > WW'(1)) : (r_fh > HW'(1));
        seed_lim    = r_sphase ? LW'(r_fh) : LW'(r_fw);
    end

    always_comb begin
        rd_word = '0;
        if (r_rd_ok) begin
            rd_word.valid_res   = 1'b1;
            rd_word.out_red     = r_pix_rd.red;
            rd_word.out_green   = r_pix_rd.green;
            rd_word.out_blue    = r_pix_rd.blue;
            rd_word.out_alpha   = r_pix_rd.alpha;
            rd_word.was_cleared = r_flag_rd[1];
            rd_word.last_pixel  = r_rd_last;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_bright     = r_bright;
        n_tol        = r_tol;
        n_width_cfg  = r_width_cfg;
        n_height_cfg = r_height_cfg;
        n_load       = r_load;
        n_read       = r_read;
        n_ready      = r_ready;
        n_dirty      = r_dirty;
        n_fw         = r_fw;
        n_fh         = r_fh;
        n_ftot       = r_ftot;
        n_cnt        = r_cnt;
        n_seed       = r_seed;
        n_sphase     = r_sphase;
        n_sside      = r_sside;
        n_si         = r_si;
        n_px         = r_px;
        n_py         = r_py;
        n_nb         = r_nb;
        n_cx         = r_cx;
        n_cy         = r_cy;
        n_vidx       = r_vidx;
        n_head       = r_head;
        n_tail       = r_tail;
        n_rd_ok      = r_rd_ok;
        n_rd_last    = r_rd_last;
        n_out_v      = r_out_v;
        n_out        = r_out;
        n_skid_v     = r_skid_v;
        n_skid       = r_skid;
        pix_we       = 1'b0;
        pix_waddr    = r_load;
        pix_wdata    = '0;
        pm_raddr     = (r_state == S_VIS) ? mul_idx : r_read;
        flag_we      = 1'b0;
        flag_waddr   = r_vidx;
        flag_wdata   = FLAG_NONE;
        q_we         = 1'b0;
        q_wdata      = {r_cx, r_cy};
        adv          = 1'b0;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                bfbg_pkg::REG_BRIGHT: n_bright     = i_cfg_data;
                bfbg_pkg::REG_TOL:    n_tol        = i_cfg_data;
                bfbg_pkg::REG_WIDTH:  n_width_cfg  = i_cfg_data;
                bfbg_pkg::REG_HEIGHT: n_height_cfg = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_word.func == bfbg_pkg::FUNC_LOAD) begin
                        pix_we          = 1'b1;
                        pix_waddr       = r_load;
                        pix_wdata.red   = i_in_word.red;
                        pix_wdata.green = i_in_word.green;
                        pix_wdata.blue  = i_in_word.blue;
                        pix_wdata.alpha = i_in_word.alpha;
                        n_ready         = 1'b0;
                        if (load_next >= tot_full) begin
                            n_load  = '0;
                            n_read  = '0;
                            n_fw    = w_eff;
                            n_fh    = h_eff;
                            n_ftot  = tot_full[TW-1:0];
                            n_cnt   = '0;
                            n_state = S_SWEEP;
                        end else begin
                            n_load = r_load + AW'(1);
                        end
                    end else begin
                        n_rd_ok   = r_ready;
                        n_rd_last = (read_next >= tot_full);
                        if (r_ready) begin
                            if (read_next >= tot_full) begin
                                n_ready = 1'b0;
                                n_read  = '0;
                            end else begin
                                n_read = r_read + AW'(1);
                            end
                        end
                        n_state = S_RDW;
                    end
                end
            end
            S_RDW: begin
                n_state = S_IDLE;
            end
            S_SWEEP: begin
                if (r_cnt < r_dirty) begin
                    flag_we    = 1'b1;
                    flag_waddr = r_cnt[AW-1:0];
                    flag_wdata = FLAG_NONE;
                    n_cnt      = r_cnt + TW'(1);
                end else begin
                    n_dirty  = r_ftot;
                    n_seed   = 1'b1;
                    n_sphase = 1'b0;
                    n_sside  = 1'b0;
                    n_si     = '0;
                    n_head   = '0;
                    n_tail   = '0;
                    n_state  = S_VIS;
                end
            end
            S_VIS: begin
                if (cand_ok) begin
                    n_cx    = cand_x;
                    n_cy    = cand_y;
                    n_vidx  = mul_idx;
                    n_state = S_CHK;
                end else begin
                    adv = 1'b1;
                end
            end
            S_CHK: begin
                if (!r_flag_rd[0]) begin
                    flag_we    = 1'b1;
                    flag_waddr = r_vidx;
                    flag_wdata = FLAG_VISITED;
                    if (is_bg) begin
                        q_we   = 1'b1;
                        n_tail = r_tail + TW'(1);
                    end
                end
                adv = 1'b1;
            end
            S_DEQ: begin
                if (r_head == r_tail) begin
                    n_ready = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_head  = r_head + TW'(1);
                    n_state = S_DEQ2;
                end
            end
            S_DEQ2: begin
                pix_we     = 1'b1;
                pix_waddr  = mul_idx;
                pix_wdata  = '0;
                flag_we    = 1'b1;
                flag_waddr = mul_idx;
                flag_wdata = FLAG_CLEARED;
                n_px       = r_q_rd[QW-1:YW];
                n_py       = r_q_rd[YW-1:0];
                n_nb       = NB_LEFT;
                n_state    = S_VIS;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (adv) begin
            n_state = S_VIS;
            if (r_seed) begin
                if (!r_sside && seed_second) begin
                    n_sside = 1'b1;
                end else begin
                    n_sside = 1'b0;
                    if ((r_si + LW'(1)) == seed_lim) begin
                        n_si = '0;
                        if (!r_sphase) begin
                            n_sphase = 1'b1;
                        end else begin
                            n_seed  = 1'b0;
                            n_state = S_DEQ;
                        end
                    end else begin
                        n_si = r_si + LW'(1);
                    end
                end
            end else begin
                if (r_nb == NB_DOWN) begin
                    n_state = S_DEQ;
                end else begin
                    n_nb = r_nb + 2'd1;
                end
            end
        end

        if (out_take) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end
        if (r_state == S_RDW) begin
            if (!n_out_v) begin
                n_out   = rd_word;
                n_out_v = 1'b1;
            end else begin
                n_skid   = rd_word;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_we) begin
            r_pix_mem[pix_waddr] <= pix_wdata;
        end
        r_pix_rd <= r_pix_mem[pm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (flag_we) begin
            r_flag_mem[flag_waddr] <= flag_wdata;
        end
        r_flag_rd <= r_flag_mem[pm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_q_mem[r_tail[AW-1:0]] <= q_wdata;
        end
        r_q_rd <= r_q_mem[r_head[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_bright     <= bfbg_pkg::BRIGHT_RESET;
            r_tol        <= bfbg_pkg::TOL_RESET;
            r_width_cfg  <= bfbg_pkg::DIM_RESET;
            r_height_cfg <= bfbg_pkg::DIM_RESET;
            r_load       <= '0;
            r_read       <= '0;
            r_ready      <= 1'b0;
            r_dirty      <= TW'(DEPTH);
            r_cnt        <= '0;
            r_seed       <= 1'b0;
            r_head       <= '0;
            r_tail       <= '0;
            r_out_v      <= 1'b0;
            r_skid_v     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_bright     <= n_bright;
            r_tol        <= n_tol;
            r_width_cfg  <= n_width_cfg;
            r_height_cfg <= n_height_cfg;
            r_load       <= n_load;
            r_read       <= n_read;
            r_ready      <= n_ready;
            r_dirty      <= n_dirty;
            r_cnt        <= n_cnt;
            r_seed       <= n_seed;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_out_v      <= n_out_v;
            r_skid_v     <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw      <= n_fw;
        r_fh      <= n_fh;
        r_ftot    <= n_ftot;
        r_sphase  <= n_sphase;
        r_sside   <= n_sside;
        r_si      <= n_si;
        r_px      <= n_px;
        r_py      <= n_py;
        r_nb      <= n_nb;
        r_cx      <= n_cx;
        r_cy      <= n_cy;
        r_vidx    <= n_vidx;
        r_rd_ok   <= n_rd_ok;
        r_rd_last <= n_rd_last;
        r_out     <= n_out;
        r_skid    <= n_skid;
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> r_out_v)
        else $error("second output stage holds a word while the first is empty");

    a_queue_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= r_tail) && (r_tail <= TW'(DEPTH)))
        else $error("fill queue pointers out of order");

    a_no_ready_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE && r_state != S_RDW) |-> !r_ready)
        else $error("image marked ready while a fill is running");

    a_chk_after_vis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHK) |-> ($past(r_state) == S_VIS))
        else $error("neighbour check without a preceding memory read");

endmodule
